// File: design/rqve_pkg.sv
// Shared types, constants and helper functions for the rotated quad vertex expander.
// Depends on nothing; every other file of the block but rqve_if imports it.
package rqve_pkg;

  localparam int CORDIC_ITERS = 24;
  localparam int VERTS_PER_SPRITE = 6;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_SPRITE - 1);

  // Sprite fields other than the angle, carried alongside the rotation.
  typedef struct packed {
    logic [30:0]        w;
    logic [30:0]        h;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] z;
    logic [15:0]        u_l;
    logic [15:0]        u_r;
    logic [15:0]        v_t;
    logic [15:0]        v_b;
    logic               last;
  } sprite_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
  } cordic_t;

  // One queue entry: the sprite with its cosine and sine (Q2.30).
  typedef struct packed {
    sprite_t            spr;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } entry_t;

  // Handshake between the front and the queue.
  typedef struct packed {
    logic full;
  } qctl_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [31:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 32'sd536870912;
      1:  atan_turn = 32'sd316933406;
      2:  atan_turn = 32'sd167458907;
      3:  atan_turn = 32'sd85004756;
      4:  atan_turn = 32'sd42667331;
      5:  atan_turn = 32'sd21354465;
      6:  atan_turn = 32'sd10679838;
      7:  atan_turn = 32'sd5340245;
      8:  atan_turn = 32'sd2670163;
      9:  atan_turn = 32'sd1335087;
      10: atan_turn = 32'sd667544;
      11: atan_turn = 32'sd333772;
      12: atan_turn = 32'sd166886;
      13: atan_turn = 32'sd83443;
      14: atan_turn = 32'sd41722;
      15: atan_turn = 32'sd20861;
      16: atan_turn = 32'sd10430;
      17: atan_turn = 32'sd5215;
      18: atan_turn = 32'sd2608;
      19: atan_turn = 32'sd1304;
      20: atan_turn = 32'sd652;
      21: atan_turn = 32'sd326;
      22: atan_turn = 32'sd163;
      23: atan_turn = 32'sd81;
      default: atan_turn = 32'sd0;
    endcase
  endfunction

  // Corner order BL, BR, TL, BR, TL, TR: true where the corner is on the left.
  function automatic logic corner_left(input logic [2:0] k);
    case (k)
      3'd0, 3'd2, 3'd4: corner_left = 1'b1;
      default:          corner_left = 1'b0;
    endcase
  endfunction

  // True where the corner is on the bottom edge.
  function automatic logic corner_bottom(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd3: corner_bottom = 1'b1;
      default:          corner_bottom = 1'b0;
    endcase
  endfunction

endpackage

// File: design/rqve_if.sv
// Channel interfaces of the expander: sprites in, vertices out.
// Plain valid/ready channels; no package dependency.
interface rqve_sprite_if #(parameter int ANGLE_BITS = 16) ();
  logic                  valid;
  logic                  ready;
  logic [30:0]           half_source_width;
  logic [30:0]           sprite_height;
  logic signed [31:0]    centre_x;
  logic signed [31:0]    centre_y;
  logic signed [31:0]    depth_z;
  logic [ANGLE_BITS-1:0] turn_angle;
  logic [15:0]           tex_u_left;
  logic [15:0]           tex_u_right;
  logic [15:0]           tex_v_top;
  logic [15:0]           tex_v_bottom;
  logic                  last_sprite;

  modport source (output valid, half_source_width, sprite_height, centre_x, centre_y,
                  depth_z, turn_angle, tex_u_left, tex_u_right, tex_v_top, tex_v_bottom,
                  last_sprite, input ready);
  modport sink (input valid, half_source_width, sprite_height, centre_x, centre_y,
                depth_z, turn_angle, tex_u_left, tex_u_right, tex_v_top, tex_v_bottom,
                last_sprite, output ready);
endinterface

interface rqve_vertex_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic [15:0]        vertex_u;
  logic [15:0]        vertex_v;
  logic               last_vertex;
  logic               end_of_list;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_u, vertex_v,
                  last_vertex, end_of_list, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, vertex_u, vertex_v,
                last_vertex, end_of_list, output ready);
endinterface

// File: design/rqve_front.sv
// Front of the expander: accepts sprites and runs a pipelined CORDIC for cos and sin.
// Depends on rqve_pkg and rqve_sprite_if.
module rqve_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  rqve_sprite_if.sink        sprite,
  input  rqve_pkg::qctl_t    qin,
  output logic               push,
  output rqve_pkg::entry_t   entry
);
  import rqve_pkg::*;

  cordic_t    st  [CORDIC_ITERS+1];
  sprite_t    pay [CORDIC_ITERS+1];
  logic [CORDIC_ITERS:0] vld;
  logic       adv;
  logic [31:0] a_turn;
  logic [31:0] a_round;
  logic [1:0]  quad0;
  cordic_t     st_in;

  // The whole pipeline moves together; it holds only when its tail cannot leave.
  assign adv = !vld[CORDIC_ITERS] || !qin.full;
  assign push = vld[CORDIC_ITERS] && !qin.full;
  assign sprite.ready = adv;

  always_comb begin
    a_turn  = {sprite.turn_angle, {(32-ANGLE_BITS){1'b0}}};
    a_round = a_turn + 32'h2000_0000;
    quad0   = a_round[31:30];
    st_in.x = CORDIC_GAIN;
    st_in.y = 32'sd0;
    st_in.z = $signed(a_turn - {quad0, 30'd0});
    st_in.quad = quad0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[CORDIC_ITERS-1:0], sprite.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st_in;
      pay[0] <= '{w: sprite.half_source_width, h: sprite.sprite_height,
                  cx: sprite.centre_x, cy: sprite.centre_y, z: sprite.depth_z,
                  u_l: sprite.tex_u_left, u_r: sprite.tex_u_right,
                  v_t: sprite.tex_v_top, v_b: sprite.tex_v_bottom,
                  last: sprite.last_sprite};
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        pay[i+1] <= pay[i];
        st[i+1].quad <= st[i].quad;
        if (!st[i].z[31]) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - atan_turn(i);
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + atan_turn(i);
        end
      end
    end
  end

  // Quadrant restore on the way into the queue.
  always_comb begin
    entry.spr = pay[CORDIC_ITERS];
    case (st[CORDIC_ITERS].quad)
      2'd0: begin
        entry.c = st[CORDIC_ITERS].x;
        entry.s = st[CORDIC_ITERS].y;
      end
      2'd1: begin
        entry.c = -st[CORDIC_ITERS].y;
        entry.s = st[CORDIC_ITERS].x;
      end
      2'd2: begin
        entry.c = -st[CORDIC_ITERS].x;
        entry.s = -st[CORDIC_ITERS].y;
      end
      default: begin
        entry.c = st[CORDIC_ITERS].y;
        entry.s = -st[CORDIC_ITERS].x;
      end
    endcase
  end

endmodule

// File: design/rqve_queue.sv
// Two-entry queue of rotated sprites between the front and the back.
// Depends on rqve_pkg.
module rqve_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rqve_pkg::entry_t wdata,
  output rqve_pkg::qctl_t  qout,
  input  logic             pop,
  output logic             nonempty,
  output rqve_pkg::entry_t rdata
);
  import rqve_pkg::*;

  entry_t     mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign nonempty   = count != 2'd0;
  assign qout.full  = count == 2'd2;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// File: design/rqve_back.sv
// Back of the expander: forms the four corner products and emits six vertices per sprite.
// Depends on rqve_pkg and rqve_vertex_if.
module rqve_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rqve_pkg::entry_t q_data,
  output logic             pop,
  rqve_vertex_if.source    vertex
);
  import rqve_pkg::*;

  logic signed [63:0] cw, sh, ch, sw;
  sprite_t    spr;
  logic       pv;
  logic [2:0] k;
  logic       ov;
  logic       load_out;
  logic       done;
  logic signed [63:0] sum_x, sum_y;
  logic signed [31:0] px, py;
  logic       left, bottom;

  assign load_out = pv && (!ov || vertex.ready);
  assign done = load_out && (k == LAST_VERT);
  assign pop = q_valid && (!pv || done);
  assign vertex.valid = ov;
  assign left = corner_left(k);
  assign bottom = corner_bottom(k);

  function automatic logic signed [31:0] place(input logic signed [63:0] sum,
                                               input logic signed [31:0] centre);
    logic signed [63:0] r;
    logic signed [33:0] v;
    begin
      r = (sum + 64'sd1073741824) >>> 31;
      v = 34'(r) + 34'(centre);
      if (v > 34'sd2147483647) place = 32'sh7fff_ffff;
      else if (v < -34'sd2147483648) place = 32'sh8000_0000;
      else place = v[31:0];
    end
  endfunction

  always_comb begin
    sum_x = (left ? -cw : cw) + (bottom ? -sh : sh);
    sum_y = (bottom ? -ch : ch) - (left ? -sw : sw);
    px = place(sum_x, spr.cx);
    py = place(sum_y, spr.cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      k  <= 3'd0;
      ov <= 1'b0;
    end else begin
      if (pop) pv <= 1'b1;
      else if (done) pv <= 1'b0;
      if (done) k <= 3'd0;
      else if (load_out) k <= k + 3'd1;
      if (load_out) ov <= 1'b1;
      else if (vertex.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      spr <= q_data.spr;
      cw  <= q_data.c * $signed({33'd0, q_data.spr.w});
      sh  <= q_data.s * $signed({33'd0, q_data.spr.h});
      ch  <= q_data.c * $signed({33'd0, q_data.spr.h});
      sw  <= q_data.s * $signed({33'd0, q_data.spr.w});
    end
    if (load_out) begin
      vertex.vertex_x    <= px;
      vertex.vertex_y    <= py;
      vertex.vertex_z    <= spr.z;
      vertex.vertex_u    <= left ? spr.u_l : spr.u_r;
      vertex.vertex_v    <= bottom ? spr.v_b : spr.v_t;
      vertex.last_vertex <= k == LAST_VERT;
      vertex.end_of_list <= (k == LAST_VERT) && spr.last;
    end
  end

endmodule

// File: design/rotated_quad_vertex_expander_unit.sv
// Top level of the rotated sprite quad expander.
// Depends on rqve_pkg, rqve_if, rqve_front, rqve_queue and rqve_back.
//
// Each sprite item taken on the sprite channel yields six vertex items on the
// vertex channel, in the order bottom-left, bottom-right, top-left,
// bottom-right, top-left, top-right, so that they form two triangles. Cosine
// and sine of the rotation come from a pipelined CORDIC in the front
// part, which takes a new sprite in every cycle it is not held; a two-entry
// queue then decouples it from the back part. The back part forms the four
// corner products as it takes a sprite from the queue and then writes one
// vertex per cycle into the output register while the vertex channel is not
// held, so the sustained rate is set by the single vertex output port.
// Positions are rounded and saturated to signed Q16.16; depth and texture
// coordinates pass through unchanged.
module rotated_quad_vertex_expander_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  rqve_sprite_if.sink   sprite,
  rqve_vertex_if.source vertex
);
  import rqve_pkg::*;

  entry_t f_entry;
  entry_t q_entry;
  qctl_t  qctl;
  logic   f_push;
  logic   q_valid;
  logic   q_pop;

  // Front: sprite acceptance and the CORDIC pipeline.
  rqve_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .sprite (sprite),
    .qin    (qctl),
    .push   (f_push),
    .entry  (f_entry)
  );

  // Short queue so that each side can stall on its own.
  rqve_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wdata    (f_entry),
    .qout     (qctl),
    .pop      (q_pop),
    .nonempty (q_valid),
    .rdata    (q_entry)
  );

  // Back: corner products and vertex emission.
  rqve_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_entry),
    .pop     (q_pop),
    .vertex  (vertex)
  );

endmodule

// File: dv/tb_rotated_quad_vertex_expander_unit.sv
// Self-checking testbench for the rotated quad vertex expander: sprites in, six vertices out.
// Depends on rqve_pkg, rqve_if and rotated_quad_vertex_expander_unit; uses its own CORDIC predictor.
module tb_rotated_quad_vertex_expander_unit;
  import rqve_pkg::*;

  // One expected vertex, held in the order the block must emit it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        u;
    logic [15:0]        v;
    logic               last_vertex;
    logic               end_of_list;
  } vertex_t;

  // One row of the directed stimulus. Where the vertices can be read straight off
  // the inputs, the first expected position is typed in and checked against the predictor.
  typedef struct {
    logic [30:0]        w;
    logic [30:0]        h;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] z;
    logic [15:0]        ang;
    logic [15:0]        ul;
    logic [15:0]        ur;
    logic [15:0]        vt;
    logic [15:0]        vb;
    logic               last;
    logic               typed;
    logic signed [31:0] bl_x;
    logic signed [31:0] bl_y;
  } sprite_row_t;

  localparam int DIRECTED_ROWS = 16;
  localparam int RANDOM_SPRITES = 445;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  rqve_sprite_if #(.ANGLE_BITS(16)) sprite ();
  rqve_vertex_if vertex ();

  rotated_quad_vertex_expander_unit #(.ANGLE_BITS(16)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sprite (sprite.sink),
    .vertex (vertex.source)
  );

  vertex_t     pending_vertices[$];
  int          mismatch_count;
  longint      cycle_count;
  bit          quiet_phase;
  bit          hold_request;
  sprite_row_t directed_rows[DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Arithmetic shift right with floor rounding on a 64-bit signed value.
  function automatic longint floor_shift(input longint v, input int k);
    return v >>> k;
  endfunction

  // Cosine and sine in Q2.30 from a 24-step CORDIC on the residual angle,
  // with the quadrant folded back in afterwards.
  task automatic rotation_terms(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic [1:0]  q;
    logic [31:0] r;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0};
    q = 2'((a + 32'h2000_0000) >> 30);
    r = a - ({30'd0, q} << 30);
    z = longint'($signed(r));
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Rounds a product sum back to Q16.16 (halving w and h), adds the centre and saturates.
  function automatic logic signed [31:0] place_coord(input longint sum, input longint centre);
    longint v;
    v = floor_shift(sum + (64'sd1 <<< 30), 31) + centre;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  // Works out the six vertices of one sprite and queues them.
  task automatic expand_sprite(input sprite_row_t r);
    longint  c, s, px, py;
    vertex_t e;
    rotation_terms(r.ang, c, s);
    for (int k = 0; k < VERTS_PER_SPRITE; k++) begin
      px = corner_left(3'(k)) ? -longint'(r.w) : longint'(r.w);
      py = corner_bottom(3'(k)) ? -longint'(r.h) : longint'(r.h);
      e.x = place_coord(c * px + s * py, longint'(r.cx));
      e.y = place_coord(c * py - s * px, longint'(r.cy));
      e.z = r.z;
      e.u = corner_left(3'(k)) ? r.ul : r.ur;
      e.v = corner_bottom(3'(k)) ? r.vb : r.vt;
      e.last_vertex = (k == VERTS_PER_SPRITE - 1);
      e.end_of_list = (k == VERTS_PER_SPRITE - 1) ? r.last : 1'b0;
      pending_vertices.push_back(e);
    end
  endtask

  function automatic sprite_row_t random_sprite();
    sprite_row_t r;
    int          mode;
    mode = $urandom_range(0, 9);
    // Mostly moderate sizes so that positions stay in range, with some full-width
    // values so that saturation and the top bits are exercised.
    if (mode < 7) begin
      r.w = 31'($urandom_range(0, 32'h00FF_FFFF));
      r.h = 31'($urandom_range(0, 32'h00FF_FFFF));
      r.cx = $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
      r.cy = $signed(32'($urandom_range(0, 32'h0FFF_FFFF))) - 32'sh0800_0000;
    end else begin
      r.w = 31'($urandom());
      r.h = 31'($urandom());
      r.cx = $signed($urandom());
      r.cy = $signed($urandom());
    end
    r.z = $signed($urandom());
    r.ang = 16'($urandom());
    r.ul = 16'($urandom());
    r.ur = 16'($urandom());
    r.vt = 16'($urandom());
    r.vb = 16'($urandom());
    r.last = ($urandom_range(0, 7) == 0);
    r.typed = 1'b0;
    r.bl_x = '0;
    r.bl_y = '0;
    return r;
  endfunction

  function automatic sprite_row_t make_row(input logic [30:0] w, input logic [30:0] h,
                                           input logic signed [31:0] cx,
                                           input logic signed [31:0] cy,
                                           input logic [15:0] ang, input logic last);
    sprite_row_t r;
    r.w = w; r.h = h; r.cx = cx; r.cy = cy; r.ang = ang; r.last = last;
    r.z = $signed($urandom());
    r.ul = 16'h0000; r.ur = 16'hFFFF; r.vt = 16'h0000; r.vb = 16'hFFFF;
    r.typed = 1'b0; r.bl_x = '0; r.bl_y = '0;
    return r;
  endfunction

  // Directed rows: a zero-size sprite, the four cardinal angles, extremes of size,
  // centre and depth that drive saturation both ways, reversed texture edges,
  // and the final-sprite flag.
  initial begin
    directed_rows[0] = make_row('0, '0, '0, '0, 16'h0000, 1'b0);
    directed_rows[0].z = '0;
    directed_rows[0].typed = 1'b1;
    directed_rows[1] = make_row(31'h0002_0000, 31'h0004_0000, 32'sh0010_0000, 32'sh0020_0000,
                                16'h0000, 1'b0);
    directed_rows[2] = make_row(31'h0002_0000, 31'h0004_0000, '0, '0, 16'h4000, 1'b0);
    directed_rows[3] = make_row(31'h0002_0000, 31'h0004_0000, '0, '0, 16'h8000, 1'b0);
    directed_rows[4] = make_row(31'h0002_0000, 31'h0004_0000, '0, '0, 16'hC000, 1'b1);
    directed_rows[5] = make_row(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                16'h2000, 1'b0);
    directed_rows[6] = make_row(31'h7FFF_FFFF, 31'h7FFF_FFFF, -32'sh8000_0000,
                                -32'sh8000_0000, 16'hFFFF, 1'b0);
    // Zero size at the extreme centres: every corner sits on the centre itself.
    directed_rows[7] = make_row('0, '0, 32'sh7FFF_FFFF, -32'sh8000_0000, 16'h1234, 1'b0);
    directed_rows[7].typed = 1'b1;
    directed_rows[7].bl_x = 32'sh7FFF_FFFF;
    directed_rows[7].bl_y = -32'sh8000_0000;
    directed_rows[8] = make_row(31'h7FFF_FFFF, '0, '0, '0, 16'h0000, 1'b0);
    directed_rows[9] = make_row('0, 31'h7FFF_FFFF, '0, '0, 16'h4000, 1'b0);
    directed_rows[10] = make_row(31'h0001_0000, 31'h0001_0000, '0, '0, 16'h0001, 1'b0);
    directed_rows[10].ul = 16'hFFFF; directed_rows[10].ur = 16'h0000;
    directed_rows[10].vt = 16'hFFFF; directed_rows[10].vb = 16'h0000;
    directed_rows[11] = make_row(31'h0001_0000, 31'h0001_0000, '0, '0, 16'h7FFF, 1'b0);
    directed_rows[11].z = 32'sh7FFF_FFFF;
    directed_rows[12] = make_row(31'h0001_0000, 31'h0001_0000, '0, '0, 16'h5555, 1'b0);
    directed_rows[12].z = -32'sh8000_0000;
    directed_rows[13] = make_row(31'h5555_5555, 31'h2AAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                                16'hAAAA, 1'b0);
    directed_rows[14] = make_row(31'h0000_0001, 31'h0000_0001, '0, '0, 16'hE000, 1'b0);
    directed_rows[15] = make_row(31'h0010_0000, 31'h0010_0000, '0, '0, 16'h6000, 1'b1);
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Long receiver hold-off, timed in cycles by its own process.
  initial begin
    hold_request = 1'b0;
    wait (cycle_count == 2000);
    @(posedge clk);
    hold_request <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_request <= 1'b0;
  end

  // Receiver: random stalls about 23 percent of the time, none during the quiet
  // stretch, and a full stop while the long hold is requested.
  always @(posedge clk) begin
    if (rst) begin
      vertex.ready <= 1'b0;
    end else begin
      vertex.ready <= !hold_request && (quiet_phase || ($urandom_range(0, 99) >= 23));
    end
  end

  // Checks each accepted vertex against the oldest expected one.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vertex.valid && vertex.ready) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("vertex with none expected", 0, 0);
      end else begin
        e = pending_vertices.pop_front();
        if (vertex.vertex_x !== e.x) report_mismatch("vertex_x", vertex.vertex_x, e.x);
        if (vertex.vertex_y !== e.y) report_mismatch("vertex_y", vertex.vertex_y, e.y);
        if (vertex.vertex_z !== e.z) report_mismatch("vertex_z", vertex.vertex_z, e.z);
        if (vertex.vertex_u !== e.u) report_mismatch("vertex_u", vertex.vertex_u, e.u);
        if (vertex.vertex_v !== e.v) report_mismatch("vertex_v", vertex.vertex_v, e.v);
        if (vertex.last_vertex !== e.last_vertex)
          report_mismatch("last_vertex", vertex.last_vertex, e.last_vertex);
        if (vertex.end_of_list !== e.end_of_list)
          report_mismatch("end_of_list", vertex.end_of_list, e.end_of_list);
      end
    end
  end

  // Offers one sprite with random idle cycles in front of it, and waits for acceptance.
  task automatic offer_sprite(input sprite_row_t r);
    while (!quiet_phase && $urandom_range(0, 99) < 23) begin
      sprite.valid <= 1'b0;
      @(posedge clk);
    end
    sprite.valid <= 1'b1;
    sprite.half_source_width <= r.w;
    sprite.sprite_height <= r.h;
    sprite.centre_x <= r.cx;
    sprite.centre_y <= r.cy;
    sprite.depth_z <= r.z;
    sprite.turn_angle <= r.ang;
    sprite.tex_u_left <= r.ul;
    sprite.tex_u_right <= r.ur;
    sprite.tex_v_top <= r.vt;
    sprite.tex_v_bottom <= r.vb;
    sprite.last_sprite <= r.last;
    expand_sprite(r);
    @(posedge clk);
    while (!sprite.ready) @(posedge clk);
  endtask

  initial begin
    sprite_row_t r;
    int          tail;
    mismatch_count = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    sprite.valid = 1'b0;
    sprite.half_source_width = '0;
    sprite.sprite_height = '0;
    sprite.centre_x = '0;
    sprite.centre_y = '0;
    sprite.depth_z = '0;
    sprite.turn_angle = '0;
    sprite.tex_u_left = '0;
    sprite.tex_u_right = '0;
    sprite.tex_v_top = '0;
    sprite.tex_v_bottom = '0;
    sprite.last_sprite = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Typed rows also have their bottom-left corner checked
    // against the value read straight from the inputs.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      r = directed_rows[i];
      offer_sprite(r);
      if (r.typed) begin
        if (pending_vertices[pending_vertices.size() - 6].x !== r.bl_x)
          report_mismatch("typed bottom-left x", pending_vertices[pending_vertices.size() - 6].x,
                          r.bl_x);
        if (pending_vertices[pending_vertices.size() - 6].y !== r.bl_y)
          report_mismatch("typed bottom-left y", pending_vertices[pending_vertices.size() - 6].y,
                          r.bl_y);
      end
    end

    // The sender pauses here until every expected vertex has come out.
    sprite.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_SPRITES; i++) begin
      // A stretch in the middle runs without idling on either side.
      quiet_phase = (i >= 150 && i < 230);
      offer_sprite(random_sprite());
    end
    quiet_phase = 1'b0;
    sprite.valid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < DRAIN_CYCLES) begin
      @(posedge clk);
      tail++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rqve_pkg.sv
design/rqve_if.sv
design/rqve_front.sv
design/rqve_queue.sv
design/rqve_back.sv
design/rotated_quad_vertex_expander_unit.sv
dv/tb_rotated_quad_vertex_expander_unit.sv
